### hw/rtl/rmr_pkg.sv
package rmr_pkg;

    localparam int ADDR_W    = 10;
    localparam int BYTE_W    = 8;
    localparam int WIDX_W    = 11;
    localparam int SEQ_W     = 32;
    localparam int CAP_W     = 16;
    localparam int LEN_W     = 6;
    localparam int STAT_W    = 3;
    localparam int HDR_BYTES = 4;
    localparam int HDR_W     = 32;
    localparam int S_DATA_W  = 80;
    localparam int M_DATA_W  = 24;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADLEN = 3'd2;
    localparam logic [STAT_W-1:0] ST_SMALL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVER   = 3'd4;

    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_t;

endpackage

### hw/rtl/rmr_ram.sv
module rmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/rmr_sub_unit.sv
module rmr_sub_unit import rmr_pkg::*; #(
    parameter int W          = 17,
    parameter int RING_BYTES = 1024
) (
    input  logic [W-1:0] value,
    output cmp_t         flags,
    output logic [W-1:0] diff
);

    localparam logic [W-1:0] RING_W = W'(RING_BYTES);

    assign flags.gt = value > RING_W;
    assign flags.eq = value == RING_W;
    assign diff     = value - RING_W;

endmodule

### hw/rtl/ring_message_reader_top.sv
// Channel  Dir  Request
// s_*      in   store one ring byte (tuser 0) or read the next message (tuser 1)
// m_*      out  body byte (tuser 1) or final status item (tuser 0, tlast 1)
//
// Store: the subtract unit takes ring lengths off the address until it is in range, then the byte is written.
// Read: the header is gathered in S_HDR and checked in S_CHECK, then one body byte per cycle from the
// single RAM read port while m_tready stays high, then the position update in S_POS1 and S_POS2.
// Empty or overrun reads go straight to the final status item. s_tready is high only between requests.
// Reset clears position, sequence count and control; ring contents stay undefined.
module ring_message_reader_top import rmr_pkg::*; #(
    parameter int RING_BYTES = 1024,
    parameter int MAX_MSG    = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // ring_address, ring_byte, writer_index, writer_seq, dest_capacity, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // action
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // data_byte, status, length, zero pad
    output logic [M_DATA_W-1:0] m_tdata,
    // has_data
    output logic                m_tuser,
    output logic                m_tlast
);

    localparam int AW  = $clog2(RING_BYTES);
    localparam int RPW = $clog2(RING_BYTES + 1);
    localparam int PW  = $clog2(RING_BYTES + HDR_BYTES + MAX_MSG + 1);
    localparam int WW  = (PW > ADDR_W) ? PW : ADDR_W;
    localparam int CW  = (RPW > WIDX_W) ? RPW : WIDX_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_STORE = 4'd1;
    localparam logic [3:0] S_HDR   = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_BODY  = 4'd4;
    localparam logic [3:0] S_POS1  = 4'd5;
    localparam logic [3:0] S_POS2  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;

    logic [3:0]        state_reg, state_next;
    logic [RPW-1:0]    rp_reg, rp_next;
    logic [SEQ_W-1:0]  rseq_reg, rseq_next;
    logic [WW-1:0]     wk_reg, wk_next;
    logic              mod_reg, mod_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [LEN_W-1:0]  issue_reg, issue_next;
    logic [1:0]        got_reg, got_next;
    logic              pend_reg, pend_next;
    logic              post_reg, post_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [HDR_W-1:0]  hdr_reg, hdr_next;
    logic [SEQ_W-1:0]  wseq_reg, wseq_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;

    logic              o_valid_reg, o_valid_next;
    logic [BYTE_W-1:0] o_data_reg, o_data_next;
    logic              o_has_reg, o_has_next;
    logic [STAT_W-1:0] o_status_reg, o_status_next;
    logic [LEN_W-1:0]  o_len_reg, o_len_next;
    logic              o_last_reg, o_last_next;

    logic [ADDR_W-1:0] in_addr;
    logic [BYTE_W-1:0] in_byte;
    logic [WIDX_W-1:0] in_widx;
    logic [SEQ_W-1:0]  in_wseq;
    logic [CAP_W-1:0]  in_cap;

    logic              accept;
    logic              o_free;
    logic              move;
    logic              ram_re;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;
    cmp_t              cmp;
    logic [WW-1:0]     sub_diff;
    logic [SEQ_W-1:0]  lag_in;
    logic [SEQ_W-1:0]  lag_fin;
    logic [RPW-1:0]    rp_eff;
    logic [AW-1:0]     ptr_inc;

    assign in_addr = s_tdata[9:0];
    assign in_byte = s_tdata[17:10];
    assign in_widx = s_tdata[28:18];
    assign in_wseq = s_tdata[60:29];
    assign in_cap  = s_tdata[76:61];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign o_free   = !o_valid_reg || m_tready;

    assign lag_in  = in_wseq - rseq_reg;
    assign lag_fin = wseq_reg - rseq_reg;
    assign rp_eff  = (rp_reg > RPW'(RING_BYTES - HDR_BYTES)) ? '0 : rp_reg;
    assign ptr_inc = (ptr_reg == AW'(RING_BYTES - 1)) ? '0 : ptr_reg + 1'b1;

    assign move   = pend_reg && ((state_reg == S_HDR) || o_free);
    assign ram_re = ((state_reg == S_HDR) || (state_reg == S_BODY))
                    && (issue_reg != '0) && (!pend_reg || move);
    assign ram_we = (state_reg == S_STORE) && !(cmp.gt || cmp.eq);

    rmr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wk_reg[AW-1:0]),
        .wdata (byte_reg),
        .re    (ram_re),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    rmr_sub_unit #(
        .W          (WW),
        .RING_BYTES (RING_BYTES)
    ) u_sub (
        .value (wk_reg),
        .flags (cmp),
        .diff  (sub_diff)
    );

    always_comb
    begin
        state_next    = state_reg;
        rp_next       = rp_reg;
        rseq_next     = rseq_reg;
        wk_next       = wk_reg;
        mod_next      = mod_reg;
        ptr_next      = ptr_reg;
        issue_next    = issue_reg;
        got_next      = got_reg;
        pend_next     = pend_reg;
        post_next     = post_reg;
        status_next   = status_reg;
        hdr_next      = hdr_reg;
        wseq_next     = wseq_reg;
        cap_next      = cap_reg;
        len_next      = len_reg;
        byte_next     = byte_reg;
        o_valid_next  = o_valid_reg && !m_tready;
        o_data_next   = o_data_reg;
        o_has_next    = o_has_reg;
        o_status_next = o_status_reg;
        o_len_next    = o_len_reg;
        o_last_next   = o_last_reg;

        if (ram_re)
        begin
            ptr_next   = ptr_inc;
            issue_next = issue_reg - 1'b1;
        end
        if (ram_re)
        begin
            pend_next = 1'b1;
        end
        else if (move)
        begin
            pend_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    wseq_next = in_wseq;
                    cap_next  = in_cap;
                    post_next = 1'b0;
                    if (!s_tuser)
                    begin
                        wk_next    = WW'(in_addr);
                        byte_next  = in_byte;
                        state_next = S_STORE;
                    end
                    else if (CW'(rp_reg) == CW'(in_widx))
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_FIN;
                    end
                    else if (lag_in > SEQ_W'(RING_BYTES))
                    begin
                        status_next = ST_OVER;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        rp_next    = rp_eff;
                        ptr_next   = rp_eff[AW-1:0];
                        issue_next = LEN_W'(HDR_BYTES);
                        got_next   = '0;
                        state_next = S_HDR;
                    end
                end
            end
            S_STORE:
            begin
                if (cmp.gt || cmp.eq)
                begin
                    wk_next = sub_diff;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_HDR:
            begin
                if (move)
                begin
                    hdr_next = {ram_rdata, hdr_reg[HDR_W-1:BYTE_W]};
                    got_next = got_reg + 1'b1;
                    if (got_reg == 2'd3)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if ((hdr_reg[HDR_W-1:LEN_W] != '0) || (hdr_reg[LEN_W-1:0] > LEN_W'(MAX_MSG)))
                begin
                    status_next = ST_BADLEN;
                    state_next  = S_FIN;
                end
                else if (CAP_W'(hdr_reg[LEN_W-1:0]) > cap_reg)
                begin
                    status_next = ST_SMALL;
                    state_next  = S_FIN;
                end
                else
                begin
                    issue_next = hdr_reg[LEN_W-1:0];
                    len_next   = hdr_reg[LEN_W-1:0];
                    wk_next    = WW'(rp_reg) + WW'(HDR_BYTES) + WW'(hdr_reg[LEN_W-1:0]);
                    rseq_next  = rseq_reg + SEQ_W'(HDR_BYTES)
                                 + SEQ_W'(hdr_reg[LEN_W-1:0]);
                    post_next  = 1'b1;
                    state_next = S_BODY;
                end
            end
            S_BODY:
            begin
                if (move)
                begin
                    o_valid_next  = 1'b1;
                    o_data_next   = ram_rdata;
                    o_has_next    = 1'b1;
                    o_status_next = ST_OK;
                    o_len_next    = '0;
                    o_last_next   = 1'b0;
                end
                if ((issue_reg == '0) && !pend_reg)
                begin
                    state_next = S_POS1;
                end
            end
            S_POS1:
            begin
                if (cmp.gt)
                begin
                    wk_next = sub_diff;
                end
                mod_next   = 1'b0;
                state_next = S_POS2;
            end
            S_POS2:
            begin
                if (cmp.gt || (mod_reg && cmp.eq))
                begin
                    wk_next  = sub_diff;
                    mod_next = 1'b1;
                end
                else
                begin
                    rp_next    = wk_reg[RPW-1:0];
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (o_free)
                begin
                    o_valid_next = 1'b1;
                    o_data_next  = '0;
                    o_has_next   = 1'b0;
                    o_last_next  = 1'b1;
                    o_len_next   = '0;
                    if (!post_reg)
                    begin
                        o_status_next = status_reg;
                    end
                    else if (lag_fin > SEQ_W'(RING_BYTES))
                    begin
                        o_status_next = ST_OVER;
                    end
                    else
                    begin
                        o_status_next = ST_OK;
                        o_len_next    = len_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rp_reg      <= '0;
            rseq_reg    <= '0;
            mod_reg     <= 1'b0;
            issue_reg   <= '0;
            got_reg     <= '0;
            pend_reg    <= 1'b0;
            post_reg    <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rp_reg      <= rp_next;
            rseq_reg    <= rseq_next;
            mod_reg     <= mod_next;
            issue_reg   <= issue_next;
            got_reg     <= got_next;
            pend_reg    <= pend_next;
            post_reg    <= post_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wk_reg       <= wk_next;
        ptr_reg      <= ptr_next;
        status_reg   <= status_next;
        hdr_reg      <= hdr_next;
        wseq_reg     <= wseq_next;
        cap_reg      <= cap_next;
        len_reg      <= len_next;
        byte_reg     <= byte_next;
        o_data_reg   <= o_data_next;
        o_has_reg    <= o_has_next;
        o_status_reg <= o_status_next;
        o_len_reg    <= o_len_next;
        o_last_reg   <= o_last_next;
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {7'd0, o_len_reg, o_status_reg, o_data_reg};
    assign m_tuser  = o_has_reg;
    assign m_tlast  = o_last_reg;

endmodule
